[design/gha_pkg.sv]
// ----------------------------------------------------------------------------
// gha_pkg
// Shared constants for the generational handle allocator: operation and
// status codes, port field widths and default pool geometry.
// ----------------------------------------------------------------------------
package gha_pkg;

  // Fixed widths of the word fields on the channels
  localparam int OP_W       = 2;
  localparam int IDX_PORT_W = 8;
  localparam int VER_PORT_W = 16;
  localparam int STAT_W     = 2;

  // Default pool geometry
  localparam int GHA_SLOT_COUNT   = 256;
  localparam int GHA_VERSION_BITS = 16;

  // Operation codes; the unused code behaves as a query
  localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
  localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DEAD  = 2'd2;

endpackage

[design/gha_ram.sv]
// ----------------------------------------------------------------------------
// gha_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/generational_handle_allocator_core.sv]
// ----------------------------------------------------------------------------
// generational_handle_allocator_core
// Handle allocator over a fixed pool of slots. Each slot keeps a version and
// a free-list link in two synchronous RAMs; create pops the free-list head,
// destroy checks the handle version, bumps it and appends the slot at the
// tail, query reports the current version and liveness.
//
//   channel  direction  handshake            word fields
//   in_      input      in_valid / in_stall  operation, entity_index,
//                                            entity_version
//   out_     output     out_valid/out_stall  result_index, result_version,
//                                            alive, status
//
// - Each word first issues the RAM read, then is evaluated and written back;
//   the registered read of the slot RAMs sets this split.
// - The next word is taken only once the previous one has been evaluated;
//   a stalled result holds the core in its evaluate cycle.
// - After reset a clearing pass writes version 1 and the in-order link into
//   every slot; in_stall stays high meanwhile.
// - Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module generational_handle_allocator_core
  import gha_pkg::*;
#(
  parameter int SLOT_COUNT   = GHA_SLOT_COUNT,
  parameter int VERSION_BITS = GHA_VERSION_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [IDX_PORT_W-1:0] in_entity_index,
  input  logic [VER_PORT_W-1:0] in_entity_version,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [IDX_PORT_W-1:0] out_result_index,
  output logic [VER_PORT_W-1:0] out_result_version,
  output logic                  out_alive,
  output logic [STAT_W-1:0]     out_status
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        clr_r, clr_nxt;
  logic [IDX_W-1:0]        head_r, head_nxt;
  logic [IDX_W-1:0]        tail_r, tail_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Captured word (payload, no reset)
  logic [OP_W-1:0]         op_r;
  logic [IDX_PORT_W-1:0]   idx_r;
  logic [VER_PORT_W-1:0]   ver_r;

  // Result register (payload, no reset)
  logic [IDX_PORT_W-1:0]   res_idx_r, res_idx_nxt;
  logic [VER_PORT_W-1:0]   res_ver_r, res_ver_nxt;
  logic                    res_alive_r, res_alive_nxt;
  logic [STAT_W-1:0]       res_stat_r, res_stat_nxt;

  // --------------------------------------------------------------------------
  // RAM ports
  // --------------------------------------------------------------------------
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic                    ver_we, link_we;
  logic [IDX_W-1:0]        ver_waddr, link_waddr;
  logic [VERSION_BITS-1:0] ver_wdata, ver_q;
  logic [IDX_W-1:0]        link_wdata, link_q;

  // --------------------------------------------------------------------------
  // Handshake and evaluate-cycle terms
  // --------------------------------------------------------------------------
  logic                    in_take;
  logic                    exec_go;
  logic                    clr_last;
  logic [IDX_W-1:0]        in_slot, slot;
  logic                    in_pool;
  logic [VERSION_BITS-1:0] cur_ver, bump_ver;
  logic                    hit;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // Evaluate only when the result register is free or drains this cycle
  assign exec_go  = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  assign clr_last = (clr_r == IDX_W'(SLOT_COUNT - 1));

  // Slot address from the port index (truncate or zero-extend to the pool)
  assign in_slot  = IDX_W'(in_entity_index);
  assign slot     = IDX_W'(idx_r);

  // Create reads the head slot, the others read the addressed slot
  assign rd_en    = in_take;
  assign rd_addr  = (in_operation == OP_CREATE) ? head_r : in_slot;

  // Indexes past the pool read as a dead slot with version zero
  assign in_pool  = (32'(idx_r) < SLOT_COUNT);
  assign cur_ver  = in_pool ? ver_q : '0;
  assign hit      = in_pool && (32'(cur_ver) == 32'(ver_r));
  assign bump_ver = cur_ver + VERSION_BITS'(1);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    res_idx_nxt   = res_idx_r;
    res_ver_nxt   = res_ver_r;
    res_alive_nxt = res_alive_r;
    res_stat_nxt  = res_stat_r;
    ver_we        = 1'b0;
    ver_waddr     = slot;
    ver_wdata     = bump_ver;
    link_we       = 1'b0;
    link_waddr    = slot;
    link_wdata    = slot;

    // Drop the result once taken; a new one may replace it below
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        // Write version one and the in-order link, last slot wraps to zero
        ver_we     = 1'b1;
        ver_waddr  = clr_r;
        ver_wdata  = VERSION_BITS'(1);
        link_we    = 1'b1;
        link_waddr = clr_r;
        link_wdata = clr_last ? '0 : clr_r + IDX_W'(1);
        clr_nxt    = clr_r + IDX_W'(1);
        if (clr_last) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (exec_go) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          case (op_r)
            OP_CREATE: begin
              if (count_r == '0) begin
                res_idx_nxt   = idx_r;
                res_ver_nxt   = '0;
                res_alive_nxt = 1'b0;
                res_stat_nxt  = STAT_EMPTY;
              end else begin
                // Pop the head; its link now points at itself
                head_nxt      = link_q;
                link_we       = 1'b1;
                link_waddr    = head_r;
                link_wdata    = head_r;
                count_nxt     = count_r - CNT_W'(1);
                res_idx_nxt   = IDX_PORT_W'(head_r);
                res_ver_nxt   = VER_PORT_W'(ver_q);
                res_alive_nxt = 1'b1;
                res_stat_nxt  = STAT_OK;
              end
            end

            OP_DESTROY: begin
              res_idx_nxt   = idx_r;
              res_alive_nxt = 1'b0;
              if (!hit) begin
                res_ver_nxt  = VER_PORT_W'(cur_ver);
                res_stat_nxt = STAT_DEAD;
              end else begin
                // Bump the version and append the slot at the tail
                ver_we = 1'b1;
                if (count_r != '0) begin
                  link_we    = 1'b1;
                  link_waddr = tail_r;
                  link_wdata = slot;
                end else begin
                  head_nxt = slot;
                end
                tail_nxt = slot;
                if (count_r < CNT_W'(SLOT_COUNT)) begin
                  count_nxt = count_r + CNT_W'(1);
                end
                res_ver_nxt  = VER_PORT_W'(bump_ver);
                res_stat_nxt = STAT_OK;
              end
            end

            default: begin
              // Query, and the unused code acting as query
              res_idx_nxt   = idx_r;
              res_ver_nxt   = VER_PORT_W'(cur_ver);
              res_alive_nxt = hit;
              res_stat_nxt  = STAT_OK;
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      head_r      <= '0;
      tail_r      <= IDX_W'(SLOT_COUNT - 1);
      count_r     <= CNT_W'(SLOT_COUNT);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    // Capture the word on accept; hold the result payload otherwise
    if (in_take) begin
      op_r  <= in_operation;
      idx_r <= in_entity_index;
      ver_r <= in_entity_version;
    end
    res_idx_r   <= res_idx_nxt;
    res_ver_r   <= res_ver_nxt;
    res_alive_r <= res_alive_nxt;
    res_stat_r  <= res_stat_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_result_index   = res_idx_r;
  assign out_result_version = res_ver_r;
  assign out_alive          = res_alive_r;
  assign out_status         = res_stat_r;

  // --------------------------------------------------------------------------
  // Slot memories
  // --------------------------------------------------------------------------
  gha_ram #(
    .WIDTH (VERSION_BITS),
    .DEPTH (SLOT_COUNT)
  ) u_ver_ram (
    .clk     (clk),
    .wr_en   (ver_we),
    .wr_addr (ver_waddr),
    .wr_data (ver_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ver_q)
  );

  gha_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOT_COUNT)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (link_q)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SLOT_COUNT))
    else $error("free count exceeds pool size");

  a_take_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == S_EXEC))
    else $error("accepted word did not enter evaluate cycle");

  a_create_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_go && op_r == OP_CREATE && count_r != '0) |=>
      (count_r == $past(count_r) - CNT_W'(1)))
    else $error("create did not consume a free slot");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result appeared without an evaluate cycle");

  a_alive_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_alive_r) |-> (res_stat_r == STAT_OK))
    else $error("live result carries an error status");

endmodule

[bench/generational_handle_allocator_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// generational_handle_allocator_core_tb
// Self-checking bench for the handle allocator core. A short scripted run
// hits the reset state, stale and forged handles and the spare operation
// code. Random bursts then grow the pool to exhaustion, drain it and mix
// both. Every word taken by the core is run through a local model of the
// slot versions and free list, and every result word is checked against it
// in order.
// ----------------------------------------------------------------------------
module generational_handle_allocator_core_tb;
  import gha_pkg::*;

  // The spare operation code; the core treats it as a query
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // Two copies of the pool model: one steers the stimulus as words are
  // offered, the other predicts results as the core takes words
  localparam int SIDE_PLAN  = 0;
  localparam int SIDE_CHECK = 1;

  localparam int BURSTS       = 10;
  localparam int BURST_WORDS  = 93;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [IDX_PORT_W-1:0] idx;
    logic [VER_PORT_W-1:0] ver;
  } alloc_word_t;

  typedef struct packed {
    logic [IDX_PORT_W-1:0] idx;
    logic [VER_PORT_W-1:0] ver;
    logic                  alive;
    logic [STAT_W-1:0]     status;
  } alloc_result_t;

  typedef struct packed {
    logic [IDX_PORT_W-1:0] idx;
    logic [VER_PORT_W-1:0] ver;
  } handle_t;

  // A scripted row; fixed marks a result typed in by hand
  typedef struct {
    alloc_word_t   w;
    bit            fixed;
    alloc_result_t res;
  } script_row_t;

  typedef struct {
    bit            fixed;
    alloc_result_t res;
  } hand_note_t;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_BALANCED} mix_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       in_operation = OP_QUERY;
  logic [IDX_PORT_W-1:0] in_entity_index = '0;
  logic [VER_PORT_W-1:0] in_entity_version = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [IDX_PORT_W-1:0] out_result_index;
  logic [VER_PORT_W-1:0] out_result_version;
  logic                  out_alive;
  logic [STAT_W-1:0]     out_status;

  // Pool model state, one row per copy
  logic [VER_PORT_W-1:0] slot_ver  [2][GHA_SLOT_COUNT];
  logic [IDX_PORT_W-1:0] slot_link [2][GHA_SLOT_COUNT];
  logic [IDX_PORT_W-1:0] free_head [2];
  logic [IDX_PORT_W-1:0] free_tail [2];
  logic [8:0]            free_cnt  [2];

  alloc_result_t pending_results[$];  // predicted results not yet seen
  hand_note_t    hand_notes[$];       // per offered word: hand-typed result, if any
  script_row_t   script[$];
  handle_t       live_handles[$];     // handles the stimulus believes are alive

  int  words_sent   = 0;
  int  results_seen = 0;
  int  fail_cnt     = 0;
  int  report_cnt   = 0;
  bit  calm         = 1'b0;  // no idling on either side while set

  int  n_granted = 0;
  int  n_empty   = 0;
  int  n_freed   = 0;
  int  n_stale   = 0;
  int  n_query   = 0;

  generational_handle_allocator_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_entity_index    (in_entity_index),
    .in_entity_version  (in_entity_version),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_index   (out_result_index),
    .out_result_version (out_result_version),
    .out_alive          (out_alive),
    .out_status         (out_status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Pool model
  // --------------------------------------------------------------------------

  // Link every slot in order, version 1, whole pool free
  function automatic void pool_clear(input int cp);
    for (int i = 0; i < GHA_SLOT_COUNT; i++) begin
      slot_ver[cp][i]  = VER_PORT_W'(1);
      slot_link[cp][i] = IDX_PORT_W'((i + 1 < GHA_SLOT_COUNT) ? i + 1 : 0);
    end
    free_head[cp] = '0;
    free_tail[cp] = IDX_PORT_W'(GHA_SLOT_COUNT - 1);
    free_cnt[cp]  = 9'(GHA_SLOT_COUNT);
  endfunction

  // Apply one word to a model copy and return the result word it causes
  function automatic alloc_result_t pool_apply(input int cp, input alloc_word_t w);
    alloc_result_t         r;
    logic [VER_PORT_W-1:0] cur;
    logic [IDX_PORT_W-1:0] h;
    logic                  live;
    cur      = slot_ver[cp][w.idx];
    live     = (cur == w.ver);
    r.idx    = w.idx;
    r.ver    = cur;
    r.alive  = live;
    r.status = STAT_OK;
    case (w.op)
      OP_CREATE: begin
        if (free_cnt[cp] == 0) begin
          // Empty pool: echo the index, touch nothing
          r.ver    = '0;
          r.alive  = 1'b0;
          r.status = STAT_EMPTY;
        end else begin
          h                = free_head[cp];
          free_head[cp]    = slot_link[cp][h];
          slot_link[cp][h] = h;
          free_cnt[cp]     = free_cnt[cp] - 1'b1;
          r.idx            = h;
          r.ver            = slot_ver[cp][h];
          r.alive          = 1'b1;
        end
      end
      OP_DESTROY: begin
        r.alive = 1'b0;
        if (!live) begin
          r.status = STAT_DEAD;
        end else begin
          // Append at the tail; an empty list takes the slot as its head
          if (free_cnt[cp] != 0) slot_link[cp][free_tail[cp]] = w.idx;
          else free_head[cp] = w.idx;
          slot_ver[cp][w.idx] = cur + 1'b1;  // wraps at the version width
          free_tail[cp]       = w.idx;
          if (free_cnt[cp] < GHA_SLOT_COUNT) free_cnt[cp] = free_cnt[cp] + 1'b1;
          r.ver = cur + 1'b1;
        end
      end
      default: ;  // query and the spare code report as computed above
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  function automatic void add_row(input logic [OP_W-1:0] op, input int idx, input int ver,
                                  input bit fixed, input int r_idx, input int r_ver,
                                  input bit r_alive, input logic [STAT_W-1:0] r_stat);
    script_row_t row;
    row.w.op       = op;
    row.w.idx      = IDX_PORT_W'(idx);
    row.w.ver      = VER_PORT_W'(ver);
    row.fixed      = fixed;
    row.res.idx    = IDX_PORT_W'(r_idx);
    row.res.ver    = VER_PORT_W'(r_ver);
    row.res.alive  = r_alive;
    row.res.status = r_stat;
    script.push_back(row);
  endfunction

  // Drop valid for a random number of cycles, unless in a calm stretch
  task automatic sender_gap();
    int n;
    n = 0;
    while (!calm && $urandom_range(99) < 23) n++;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offer one word and hold it until the core takes it
  task automatic send_word(input alloc_word_t w, input bit fixed, input alloc_result_t want);
    alloc_result_t planned;
    hand_note_t    note;
    planned = pool_apply(SIDE_PLAN, w);
    if (w.op == OP_CREATE && planned.status == STAT_OK)
      live_handles.push_back({planned.idx, planned.ver});
    note.fixed = fixed;
    note.res   = want;
    hand_notes.push_back(note);
    in_valid          <= 1'b1;
    in_operation      <= w.op;
    in_entity_index   <= w.idx;
    in_entity_version <= w.ver;
    do @(posedge clk); while (!(in_valid && !in_stall));
    words_sent++;
  endtask

  initial begin : stimulus
    alloc_word_t w;
    handle_t     h;
    mix_t        burst_mix [BURSTS];
    int          create_pct;
    int          destroy_pct;
    int          roll;
    int          k;

    burst_mix = '{MIX_GROW, MIX_GROW, MIX_GROW, MIX_GROW, MIX_SHRINK,
                  MIX_BALANCED, MIX_SHRINK, MIX_GROW, MIX_GROW, MIX_BALANCED};

    pool_clear(SIDE_PLAN);
    pool_clear(SIDE_CHECK);

    // Scripted run from the reset state. Fresh slots carry version 1, so a
    // version 1 handle to any free slot reads as alive.
    add_row(OP_QUERY,   8'h00, 16'h0001, 1, 8'h00, 16'h0001, 1, STAT_OK);
    add_row(OP_QUERY,   8'hFF, 16'hFFFF, 1, 8'hFF, 16'h0001, 0, STAT_OK);
    add_row(OP_SPARE,   8'hAA, 16'h5555, 1, 8'hAA, 16'h0001, 0, STAT_OK);
    add_row(OP_DESTROY, 8'h07, 16'h0000, 1, 8'h07, 16'h0001, 0, STAT_DEAD);
    add_row(OP_CREATE,  8'h33, 16'h1234, 1, 8'h00, 16'h0001, 1, STAT_OK);
    add_row(OP_CREATE,  8'hFF, 16'hFFFF, 1, 8'h01, 16'h0001, 1, STAT_OK);
    add_row(OP_DESTROY, 8'h00, 16'h0001, 1, 8'h00, 16'h0002, 0, STAT_OK);
    // stale handle after the bump: query dead, destroy refused
    add_row(OP_QUERY,   8'h00, 16'h0001, 1, 8'h00, 16'h0002, 0, STAT_OK);
    add_row(OP_DESTROY, 8'h00, 16'h0001, 1, 8'h00, 16'h0002, 0, STAT_DEAD);
    add_row(OP_QUERY,   8'h00, 16'h0002, 1, 8'h00, 16'h0002, 1, STAT_OK);
    add_row(OP_DESTROY, 8'h01, 16'h0001, 1, 8'h01, 16'h0002, 0, STAT_OK);
    // forged destroy of a free slot with the list full: the count saturates
    add_row(OP_DESTROY, 8'h05, 16'h0001, 1, 8'h05, 16'h0002, 0, STAT_OK);
    add_row(OP_CREATE,  8'h00, 16'h0000, 0, 0, 0, 0, STAT_OK);
    add_row(OP_DESTROY, 8'hFF, 16'hFFFF, 1, 8'hFF, 16'h0001, 0, STAT_DEAD);
    add_row(OP_QUERY,   8'h80, 16'h8000, 0, 0, 0, 0, STAT_OK);
    add_row(OP_CREATE,  8'h55, 16'hAAAA, 0, 0, 0, 0, STAT_OK);
    add_row(OP_CREATE,  8'hAA, 16'h5555, 0, 0, 0, 0, STAT_OK);
    add_row(OP_DESTROY, 8'h02, 16'h0001, 0, 0, 0, 0, STAT_OK);
    add_row(OP_QUERY,   8'h7F, 16'h7FFF, 0, 0, 0, 0, STAT_OK);
    add_row(OP_QUERY,   8'h00, 16'h0000, 0, 0, 0, 0, STAT_OK);
    add_row(OP_SPARE,   8'h55, 16'hAAAA, 0, 0, 0, 0, STAT_OK);
    add_row(OP_DESTROY, 8'h80, 16'h0001, 0, 0, 0, 0, STAT_OK);
    add_row(OP_CREATE,  8'hFF, 16'h0000, 0, 0, 0, 0, STAT_OK);

    // Hold reset, then release it; the core then clears its slots with in_stall up
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      sender_gap();
      send_word(script[i].w, script[i].fixed, script[i].res);
    end

    // Random bursts: grow to exhaustion, drain, then mix
    for (int b = 0; b < BURSTS; b++) begin
      calm = (b == 1);
      if (b == 4) begin
        // Pause until every result is back, so the core runs dry once
        in_valid <= 1'b0;
        do @(posedge clk); while (results_seen != words_sent);
      end
      case (burst_mix[b])
        MIX_GROW:   begin create_pct = 92; destroy_pct = 95; end
        MIX_SHRINK: begin create_pct = 20; destroy_pct = 85; end
        default:    begin create_pct = 45; destroy_pct = 82; end
      endcase
      for (int n = 0; n < BURST_WORDS; n++) begin
        roll  = $urandom_range(99);
        w.idx = IDX_PORT_W'($urandom);
        w.ver = VER_PORT_W'($urandom);
        if (roll < create_pct) begin
          w.op = OP_CREATE;  // index and version ride along, echoed on an empty pool
        end else if (roll < destroy_pct && live_handles.size() > 0) begin
          k = $urandom_range(live_handles.size() - 1);
          h = live_handles[k];
          live_handles.delete(k);
          w.op  = OP_DESTROY;
          w.idx = h.idx;
          w.ver = h.ver;
        end else begin
          case ($urandom_range(4))
            0: w.op = OP_QUERY;
            1: begin
              w.op = OP_QUERY;
              if (live_handles.size() > 0) begin
                h     = live_handles[$urandom_range(live_handles.size() - 1)];
                w.idx = h.idx;
                w.ver = h.ver;
              end
            end
            2: w.op = OP_SPARE;
            3: begin
              // stale handle: one version behind
              w.op  = OP_DESTROY;
              w.ver = slot_ver[SIDE_PLAN][w.idx] - 1'b1;
            end
            default: begin
              // forged handle with the current version, free or not
              w.op  = OP_DESTROY;
              w.ver = slot_ver[SIDE_PLAN][w.idx];
            end
          endcase
        end
        sender_gap();
        send_word(w, 1'b0, '0);
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain, then keep watching the result channel for any stray result
    do @(posedge clk); while (results_seen != words_sent);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      fail_cnt += pending_results.size();
    end

    $display("Sent %0d words: %0d creates granted, %0d refused on an empty pool, %0d destroys",
             words_sent, n_granted, n_empty, n_freed);
    $display("refused %0d stale destroys, answered %0d queries; %0d results checked",
             n_stale, n_query, results_seen);
    if (fail_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall, plus one long hold-off mid-run so the core fills
  // up and pushes back on its input while the sender keeps offering
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && words_sent >= 600) begin
        hold_done = 1'b1;
        hold_left = 90;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (!calm && $urandom_range(99) < 23);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Predict on every word taken, check every result word in order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    alloc_result_t want;
    alloc_result_t got;
    hand_note_t    note;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = pool_apply(SIDE_CHECK, {in_operation, in_entity_index, in_entity_version});
        case (in_operation)
          OP_CREATE:  if (want.status == STAT_OK) n_granted++; else n_empty++;
          OP_DESTROY: if (want.status == STAT_OK) n_freed++; else n_stale++;
          default:    n_query++;
        endcase
        // A hand-typed result takes the place of the prediction
        note = hand_notes.pop_front();
        if (note.fixed) want = note.res;
        pending_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = {out_result_index, out_result_version, out_alive, out_status};
        results_seen++;
        if (pending_results.size() == 0) begin
          fail_cnt++;
          if (report_cnt < REPORT_MAX)
            $display("%0t: result with nothing expected: idx %h ver %h alive %b status %0d",
                     $realtime, got.idx, got.ver, got.alive, got.status);
          report_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (got.idx !== want.idx || got.ver !== want.ver ||
              got.alive !== want.alive || got.status !== want.status) begin
            fail_cnt++;
            if (report_cnt < REPORT_MAX)
              $display("%0t: result %0d want %h/%h/%b/%0d got %h/%h/%b/%0d",
                       $realtime, results_seen, want.idx, want.ver, want.alive, want.status,
                       got.idx, got.ver, got.alive, got.status);
            report_cnt++;
          end
        end
      end
    end
  end

  // Hard stop well past the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
